@@ hw/rtl/trs_pkg.sv @@
// trs_pkg: shared types, constants and the per-sample operation sequence
// for the tube reservoir saturator. No dependencies; every rtl file imports it.

package trs_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC        = 24;
    localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int WORK_W      = 48;
    localparam int STORE_W     = 42;
    localparam int X_W         = 36;
    localparam int UNIT_W      = 26;
    localparam int SL_W        = 26;
    localparam int B_W         = 32;
    localparam int PC_W        = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 25;

    // sample alignment to the internal fraction
    localparam int SH_UP = (SAMPLE_BITS - 1 <= FRAC) ? FRAC - SAMPLE_BITS + 1 : 0;
    localparam int SH_DN = (SAMPLE_BITS - 1 > FRAC) ? SAMPLE_BITS - 1 - FRAC : 0;

    localparam logic signed [WORK_W-1:0] Q_ONE = WORK_W'(longint'(1) << FRAC);
    localparam logic signed [WORK_W-1:0] Q_TWO = WORK_W'(longint'(2) << FRAC);
    localparam logic signed [WORK_W-1:0] Q_THREE = WORK_W'(longint'(3) << FRAC);
    localparam logic signed [WORK_W-1:0] Q_TEN = WORK_W'(longint'(10) << FRAC);
    localparam logic signed [WORK_W-1:0] Q_FIFTEEN = WORK_W'(longint'(15) << FRAC);
    localparam logic signed [B_W-1:0] ATTEN_Q = B_W'(5536481);
    localparam logic signed [B_W-1:0] BOOST_Q = B_W'(33808632);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE = 3'd4;

    typedef enum logic [1:0] {
        MODE_SOFT   = 2'd0,
        MODE_DUAL   = 2'd1,
        MODE_SINGLE = 2'd2,
        MODE_PASS   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [23:0]        gain;
        logic signed [24:0] bias;
        logic [22:0]        size;
        logic [24:0]        rate;
    } t_cfg;

    typedef enum logic [1:0] {K_MUL, K_SL, K_PM, K_UNIT} t_kind;

    typedef enum logic [3:0] {
        A_SIN, A_X, A_X10, A_TMPUSH, A_TMPULL, A_PUSH, A_PULL, A_C,
        A_O, A_T1, A_T2, A_U, A_NABSO, A_NABSY, A_U6M15
    } t_asel;

    typedef enum logic [3:0] {
        B_GAIN, B_RATE, B_ONE, B_TWO, B_PM, B_NM, B_T1, B_T2, B_U,
        B_ATTEN, B_BOOST, B_3M2U
    } t_bsel;

    typedef enum logic [3:0] {
        D_X, D_Y, D_PUSH, D_PULL, D_PM, D_C, D_O, D_T1, D_T2, D_U
    } t_dsel;

    typedef enum logic [2:0] {
        ADD_NONE, ADD_BIAS, ADD_DST, ADD_TEN, ADD_NEG_ONE
    } t_add;

    typedef struct packed {
        t_kind kind;
        t_asel asel;
        t_bsel bsel;
        t_dsel dst;
        t_add  add;
        logic  last;
    } t_uop;

    typedef struct packed {
        logic load;
        logic start;
        logic emit;
        t_uop uop;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_stat;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_EMIT} t_state;

    localparam logic [PC_W-1:0] PC_SOFT   = 5'd1;
    localparam logic [PC_W-1:0] PC_PASS   = 5'd2;
    localparam logic [PC_W-1:0] PC_DUAL   = 5'd3;
    localparam logic [PC_W-1:0] PC_SINGLE = 5'd21;

    function automatic t_uop mk(input t_kind k, input t_asel a, input t_bsel b,
                                input t_dsel d, input t_add ad, input logic l);
        return '{kind: k, asel: a, bsel: b, dst: d, add: ad, last: l};
    endfunction

    function automatic logic [PC_W-1:0] entry_pc(input t_mode m);
        unique case (m)
            MODE_SOFT:   return PC_SOFT;
            MODE_DUAL:   return PC_DUAL;
            MODE_SINGLE: return PC_SINGLE;
            default:     return PC_PASS;
        endcase
    endfunction

    // step 0 is common, then one sequence per curve mode
    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        unique case (pc)
            5'd0:  return mk(K_MUL,  A_SIN,    B_GAIN,  D_X,    ADD_BIAS,    1'b0);
            5'd1:  return mk(K_SL,   A_X,      B_ONE,   D_Y,    ADD_NONE,    1'b1);
            5'd2:  return mk(K_MUL,  A_X,      B_ONE,   D_Y,    ADD_NONE,    1'b1);
            5'd3:  return mk(K_MUL,  A_TMPUSH, B_RATE,  D_PUSH, ADD_DST,     1'b0);
            5'd4:  return mk(K_MUL,  A_TMPULL, B_RATE,  D_PULL, ADD_DST,     1'b0);
            5'd5:  return mk(K_SL,   A_X10,    B_ONE,   D_T1,   ADD_NONE,    1'b0);
            5'd6:  return mk(K_PM,   A_T1,     B_ONE,   D_PM,   ADD_NONE,    1'b0);
            5'd7:  return mk(K_MUL,  A_PUSH,   B_PM,    D_C,    ADD_NONE,    1'b0);
            5'd8:  return mk(K_MUL,  A_PULL,   B_NM,    D_C,    ADD_DST,     1'b0);
            5'd9:  return mk(K_MUL,  A_X,      B_RATE,  D_T1,   ADD_NONE,    1'b0);
            5'd10: return mk(K_SL,   A_T1,     B_ONE,   D_T2,   ADD_NONE,    1'b0);
            5'd11: return mk(K_MUL,  A_C,      B_T2,    D_O,    ADD_NONE,    1'b0);
            5'd12: return mk(K_MUL,  A_NABSO,  B_PM,    D_PUSH, ADD_DST,     1'b0);
            5'd13: return mk(K_MUL,  A_NABSO,  B_NM,    D_PULL, ADD_DST,     1'b0);
            5'd14: return mk(K_MUL,  A_O,      B_ATTEN, D_T1,   ADD_NONE,    1'b0);
            5'd15: return mk(K_SL,   A_T1,     B_ONE,   D_T2,   ADD_NONE,    1'b0);
            5'd16: return mk(K_MUL,  A_T2,     B_BOOST, D_T1,   ADD_NONE,    1'b0);
            5'd17: return mk(K_UNIT, A_T1,     B_ONE,   D_U,    ADD_NONE,    1'b0);
            5'd18: return mk(K_MUL,  A_U,      B_U,     D_T2,   ADD_NONE,    1'b0);
            5'd19: return mk(K_MUL,  A_T2,     B_3M2U,  D_T1,   ADD_NONE,    1'b0);
            5'd20: return mk(K_MUL,  A_T1,     B_TWO,   D_Y,    ADD_NEG_ONE, 1'b1);
            5'd21: return mk(K_MUL,  A_TMPUSH, B_RATE,  D_PUSH, ADD_DST,     1'b0);
            5'd22: return mk(K_UNIT, A_X,      B_ONE,   D_U,    ADD_NONE,    1'b0);
            5'd23: return mk(K_MUL,  A_U6M15,  B_U,     D_T1,   ADD_TEN,     1'b0);
            5'd24: return mk(K_MUL,  A_U,      B_U,     D_T2,   ADD_NONE,    1'b0);
            5'd25: return mk(K_MUL,  A_T2,     B_U,     D_T2,   ADD_NONE,    1'b0);
            5'd26: return mk(K_MUL,  A_T2,     B_T1,    D_T2,   ADD_NONE,    1'b0);
            5'd27: return mk(K_MUL,  A_T2,     B_TWO,   D_T2,   ADD_NEG_ONE, 1'b0);
            5'd28: return mk(K_MUL,  A_PUSH,   B_T2,    D_T1,   ADD_NONE,    1'b0);
            5'd29: return mk(K_MUL,  A_T1,     B_RATE,  D_Y,    ADD_NONE,    1'b0);
            5'd30: return mk(K_MUL,  A_NABSY,  B_ONE,   D_PUSH, ADD_DST,     1'b1);
            default: return mk(K_MUL, A_X,     B_ONE,   D_Y,    ADD_NONE,    1'b1);
        endcase
    endfunction

endpackage

@@ hw/rtl/trs_mul.sv @@
// trs_mul: sign-magnitude fixed point multiplier, rounds half away from zero
// to the internal fraction; one shared 23x32 multiplier for the low and high halves. Uses trs_pkg.

module trs_mul import trs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [WORK_W-1:0] i_a,
    input  logic signed [B_W-1:0]    i_b,
    output logic                     o_done,
    output logic signed [WORK_W-1:0] o_res
);

    typedef enum logic [1:0] {MP_IDLE, MP_LO, MP_HI, MP_SUM} t_mul_phase;

    localparam int AM_W = 46;
    localparam int HALF_W = 23;
    localparam int PP_W = HALF_W + B_W;
    localparam logic [WORK_W-1:0] A_MAX = WORK_W'((longint'(1) << AM_W) - 1);

    t_mul_phase r_phase;
    logic r_done;
    logic [AM_W-1:0] r_amag;
    logic [B_W-1:0] r_bmag;
    logic r_neg;
    logic [PP_W-1:0] r_pp_lo, r_pp_hi;
    logic signed [WORK_W-1:0] r_res;

    logic [WORK_W-1:0] w_amag;
    logic [B_W-1:0] w_bmag;
    logic [HALF_W-1:0] w_mop;
    logic [PP_W-1:0] w_prod;
    logic [PP_W+HALF_W:0] w_sum;
    logic [WORK_W-1:0] w_mag;

    always_comb begin
        w_amag = (i_a < 0) ? WORK_W'(-i_a) : WORK_W'(i_a);
        if (w_amag > A_MAX) begin
            w_amag = A_MAX;
        end
        w_bmag = (i_b < 0) ? B_W'(-i_b) : B_W'(i_b);
        w_mop = (r_phase == MP_LO) ? r_amag[HALF_W-1:0] : r_amag[AM_W-1:HALF_W];
        w_prod = PP_W'(w_mop) * PP_W'(r_bmag);
        w_sum = {1'b0, r_pp_hi, {HALF_W{1'b0}}} + (PP_W + HALF_W + 1)'(r_pp_lo)
              + (PP_W + HALF_W + 1)'(longint'(1) << (FRAC - 1));
        w_mag = w_sum[FRAC +: WORK_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MP_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                MP_IDLE: if (i_start) r_phase <= MP_LO;
                MP_LO:   r_phase <= MP_HI;
                MP_HI:   r_phase <= MP_SUM;
                default: begin
                    r_phase <= MP_IDLE;
                    r_done <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && r_phase == MP_IDLE) begin
            r_amag <= w_amag[AM_W-1:0];
            r_bmag <= w_bmag;
            r_neg <= (i_a < 0) != (i_b < 0);
        end
        if (r_phase == MP_LO) begin
            r_pp_lo <= w_prod;
        end
        if (r_phase == MP_HI) begin
            r_pp_hi <= w_prod;
        end
        if (r_phase == MP_SUM) begin
            r_res <= r_neg ? -$signed(w_mag) : $signed(w_mag);
        end
    end

    assign o_done = r_done;
    assign o_res = r_res;

endmodule

@@ hw/rtl/trs_div.sv @@
// trs_div: soft limit v/(1+|v|) by restoring division, one quotient bit
// per cycle, rounded half away from zero. Uses trs_pkg.

module trs_div import trs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [WORK_W-1:0] i_v,
    output logic                     o_done,
    output logic signed [SL_W-1:0]   o_q
);

    localparam int UV_W = 39;
    localparam int DEN_W = UV_W + 1;
    localparam int Q_W = FRAC + 1;
    localparam int N_W = UV_W + FRAC + 1;
    localparam int CNT_W = $clog2(Q_W);
    localparam logic [WORK_W-1:0] UV_MAX = WORK_W'((longint'(1) << UV_W) - 1);

    logic r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_den, r_rem;
    logic [Q_W-1:0] r_nlo, r_q;
    logic r_neg;

    logic [WORK_W-1:0] w_uv;
    logic [DEN_W-1:0] w_den;
    logic [N_W-1:0] w_num;
    logic [DEN_W:0] w_trial;
    logic w_ge;

    always_comb begin
        w_uv = (i_v < 0) ? WORK_W'(-i_v) : WORK_W'(i_v);
        if (w_uv > UV_MAX) begin
            w_uv = UV_MAX;
        end
        w_den = DEN_W'(longint'(1) << FRAC) + DEN_W'(w_uv[UV_W-1:0]);
        w_num = {1'b0, w_uv[UV_W-1:0], {FRAC{1'b0}}} + N_W'(w_den >> 1);
        w_trial = {r_rem, r_nlo[Q_W-1]};
        w_ge = w_trial >= (DEN_W + 1)'(r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(Q_W - 1);
            r_den <= w_den;
            r_rem <= DEN_W'(w_num[N_W-1:Q_W]);
            r_nlo <= w_num[Q_W-1:0];
            r_neg <= i_v < 0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= w_ge ? DEN_W'(w_trial - (DEN_W + 1)'(r_den)) : w_trial[DEN_W-1:0];
            r_nlo <= {r_nlo[Q_W-2:0], 1'b0};
            r_q <= {r_q[Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_q = r_neg ? -$signed(SL_W'(r_q)) : $signed(SL_W'(r_q));

endmodule

@@ hw/rtl/trs_datapath.sv @@
// trs_datapath: working registers, charge stores, operand selection and
// writeback around the shared multiplier and soft limit divider.
// Uses trs_pkg, trs_mul and trs_div.

module trs_datapath import trs_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    input  t_cfg                          i_cfg,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last,
    output t_dp_stat                      o_stat,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_last
);

    localparam logic signed [STORE_W-1:0] ST_MAX = STORE_W'((longint'(1) << (STORE_W - 1)) - 1);
    localparam logic signed [STORE_W-1:0] ST_MIN = STORE_W'(-(longint'(1) << (STORE_W - 1)));
    localparam logic [WORK_W-1:0] RND_HALF =
        WORK_W'(longint'(SH_UP > 0 ? 1 : 0) << (SH_UP > 0 ? SH_UP - 1 : 0));
    localparam logic signed [WORK_W-1:0] S_HI = WORK_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [WORK_W-1:0] S_LO = WORK_W'(-(longint'(1) << (SAMPLE_BITS - 1)));

    logic signed [WORK_W-1:0]  r_sin, r_y, r_c, r_o, r_t1, r_t2;
    logic signed [X_W-1:0]     r_x;
    logic signed [STORE_W-1:0] r_push, r_pull;
    logic signed [UNIT_W-1:0]  r_u, r_pm, r_nm;
    logic r_last, r_alu_done;

    t_uop w_uop;
    logic signed [WORK_W-1:0] w_a, w_addend, w_wb, w_tgt, w_x48, w_push48, w_pull48;
    logic signed [WORK_W-1:0] w_u48, w_pmf, w_unit;
    logic signed [B_W-1:0] w_b;
    logic signed [STORE_W-1:0] w_wb_sat;
    logic w_mul_start, w_div_start, w_mul_done, w_div_done, w_wb_en;
    logic signed [WORK_W-1:0] w_mres;
    logic signed [SL_W-1:0] w_q;

    function automatic logic signed [SAMPLE_BITS-1:0] to_sample(
        input logic signed [WORK_W-1:0] v
    );
        logic signed [WORK_W-1:0] c;
        logic [WORK_W-1:0] m;
        logic signed [WORK_W-1:0] r;
        c = v;
        if (v > Q_TWO) c = Q_TWO;
        else if (v < -Q_TWO) c = -Q_TWO;
        m = (c < 0) ? WORK_W'(-c) : WORK_W'(c);
        m = ((m + RND_HALF) >> SH_UP) << SH_DN;
        r = (c < 0) ? -$signed(m) : $signed(m);
        if (r > S_HI) r = S_HI;
        else if (r < S_LO) r = S_LO;
        return r[SAMPLE_BITS-1:0];
    endfunction

    assign w_uop = i_cmd.uop;
    assign w_x48 = WORK_W'(r_x);
    assign w_push48 = WORK_W'(r_push);
    assign w_pull48 = WORK_W'(r_pull);
    assign w_u48 = WORK_W'(r_u);
    assign w_tgt = WORK_W'({i_cfg.size, 16'b0});

    always_comb begin
        unique case (w_uop.asel)
            A_SIN:    w_a = r_sin;
            A_X:      w_a = w_x48;
            A_X10:    w_a = (w_x48 <<< 3) + (w_x48 <<< 1);
            A_TMPUSH: w_a = w_tgt - w_push48;
            A_TMPULL: w_a = w_tgt - w_pull48;
            A_PUSH:   w_a = w_push48;
            A_PULL:   w_a = w_pull48;
            A_C:      w_a = r_c;
            A_O:      w_a = r_o;
            A_T1:     w_a = r_t1;
            A_T2:     w_a = r_t2;
            A_U:      w_a = w_u48;
            A_NABSO:  w_a = (r_o < 0) ? r_o : -r_o;
            A_NABSY:  w_a = (r_y < 0) ? r_y : -r_y;
            A_U6M15:  w_a = (w_u48 <<< 2) + (w_u48 <<< 1) - Q_FIFTEEN;
            default:  w_a = '0;
        endcase
    end

    always_comb begin
        unique case (w_uop.bsel)
            B_GAIN:  w_b = B_W'(i_cfg.gain);
            B_RATE:  w_b = B_W'(i_cfg.rate);
            B_ONE:   w_b = Q_ONE[B_W-1:0];
            B_TWO:   w_b = Q_TWO[B_W-1:0];
            B_PM:    w_b = B_W'(r_pm);
            B_NM:    w_b = B_W'(r_nm);
            B_T1:    w_b = r_t1[B_W-1:0];
            B_T2:    w_b = r_t2[B_W-1:0];
            B_U:     w_b = B_W'(r_u);
            B_ATTEN: w_b = ATTEN_Q;
            B_BOOST: w_b = BOOST_Q;
            B_3M2U:  w_b = B_W'(Q_THREE - (w_u48 <<< 1));
            default: w_b = '0;
        endcase
    end

    always_comb begin
        unique case (w_uop.add)
            ADD_NONE: w_addend = '0;
            ADD_BIAS: w_addend = WORK_W'(i_cfg.bias) <<< 8;
            ADD_DST: begin
                case (w_uop.dst)
                    D_C:     w_addend = r_c;
                    D_PUSH:  w_addend = w_push48;
                    D_PULL:  w_addend = w_pull48;
                    default: w_addend = '0;
                endcase
            end
            ADD_TEN:     w_addend = Q_TEN;
            ADD_NEG_ONE: w_addend = -Q_ONE;
            default:     w_addend = '0;
        endcase
    end

    always_comb begin
        w_wb = (w_uop.kind == K_SL) ? WORK_W'(w_q) : w_mres + w_addend;
        if (w_wb > WORK_W'(ST_MAX)) w_wb_sat = ST_MAX;
        else if (w_wb < WORK_W'(ST_MIN)) w_wb_sat = ST_MIN;
        else w_wb_sat = w_wb[STORE_W-1:0];
        // pm is the soft sign mapped onto [0, 1]
        w_pmf = (w_a + Q_ONE) >>> 1;
        w_unit = w_a + Q_ONE;
        if (w_unit < 0) w_unit = '0;
        else if (w_unit > Q_TWO) w_unit = Q_TWO;
        w_unit = w_unit >>> 1;
    end

    assign w_mul_start = i_cmd.start && w_uop.kind == K_MUL;
    assign w_div_start = i_cmd.start && w_uop.kind == K_SL;
    assign w_wb_en = (w_mul_done && w_uop.kind == K_MUL) || (w_div_done && w_uop.kind == K_SL);

    trs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_mul_done),
        .o_res   (w_mres)
    );

    trs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_v     (w_a),
        .o_done  (w_div_done),
        .o_q     (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push <= '0;
            r_pull <= '0;
            r_alu_done <= 1'b0;
        end else begin
            r_alu_done <= i_cmd.start && (w_uop.kind == K_PM || w_uop.kind == K_UNIT);
            if (w_wb_en && w_uop.dst == D_PUSH) r_push <= w_wb_sat;
            if (w_wb_en && w_uop.dst == D_PULL) r_pull <= w_wb_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sin <= (WORK_W'(i_sample) >>> SH_DN) <<< (SH_UP + 8);
            r_last <= i_last;
        end
        if (i_cmd.start && w_uop.kind == K_PM) begin
            r_pm <= w_pmf[UNIT_W-1:0];
            r_nm <= UNIT_W'(Q_ONE - w_pmf);
        end
        if (i_cmd.start && w_uop.kind == K_UNIT) begin
            r_u <= w_unit[UNIT_W-1:0];
        end
        if (w_wb_en) begin
            case (w_uop.dst)
                D_X:     r_x <= w_wb[X_W-1:0];
                D_Y:     r_y <= w_wb;
                D_C:     r_c <= w_wb;
                D_O:     r_o <= w_wb;
                D_T1:    r_t1 <= w_wb;
                D_T2:    r_t2 <= w_wb;
                default: ;
            endcase
        end
    end

    assign o_stat.done = w_mul_done || w_div_done || r_alu_done;
    assign o_sample = to_sample(r_y);
    assign o_last = r_last;

endmodule

@@ hw/rtl/trs_ctrl.sv @@
// trs_ctrl: sequencer state machine; steps through the operation list for
// the selected curve mode and drives the datapath. Uses trs_pkg.

module trs_ctrl import trs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_fire,
    input  t_mode    i_mode,
    input  logic     i_out_free,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    t_uop w_uop;

    assign w_uop = ucode(r_pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc <= '0;
        end else begin
            r_state <= n_state;
            r_pc <= n_pc;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pc = r_pc;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    n_state = S_ISSUE;
                    n_pc = '0;
                end
            end
            S_ISSUE: n_state = S_WAIT;
            S_WAIT: begin
                if (i_stat.done) begin
                    if (w_uop.last) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_ISSUE;
                        // after the common gain step, branch to the mode's sequence
                        n_pc = (r_pc == '0) ? entry_pc(i_mode) : r_pc + 1'b1;
                    end
                end
            end
            S_EMIT: if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = r_state == S_IDLE;
        o_cmd.load = r_state == S_IDLE && i_in_fire;
        o_cmd.start = r_state == S_ISSUE;
        o_cmd.emit = r_state == S_EMIT && i_out_free;
        o_cmd.uop = w_uop;
    end

endmodule

@@ hw/rtl/tube_reservoir_saturator.sv @@
// tube_reservoir_saturator: top level with configuration registers and the
// output register. Uses trs_pkg, trs_ctrl and trs_datapath.
//
// Samples enter on the s_axis channel (tdata = sample_in, tlast = block_end)
// and leave on the m_axis channel (tdata = sample_out, tlast = block_end_out),
// one result per sample, in order. Registers are written on the cfg channel,
// which is always ready; write only while no sample is in flight.
// Each sample is processed alone by a sequencer driving one shared multiplier
// and one bit-serial soft limit divider. The next sample is taken in the cycle after
// the result of the one before moves into the output register.
// The output register holds a finished result while the receiver stalls;
// a new sample is accepted meanwhile, and its result waits until the register
// is free. Reset is synchronous: it empties the output register, clears both
// charge stores and loads the default registers (mode 1, gain 67830, bias 0,
// size 512, rate 8388608).

module tube_reservoir_saturator import trs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [TDATA_W-1:0]    i_s_axis_tdata,  // sample_in
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [TDATA_W-1:0]    o_m_axis_tdata,  // sample_out
    output logic                  o_m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic r_ovalid, r_olast;
    logic signed [SAMPLE_BITS-1:0] r_osample;

    logic w_in_ready, w_in_fire, w_out_free, w_dp_last;
    logic signed [SAMPLE_BITS-1:0] w_dp_sample;
    t_dp_cmd w_cmd;
    t_dp_stat w_stat;

    assign w_in_fire = i_s_axis_tvalid && w_in_ready;
    assign w_out_free = !r_ovalid || i_m_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= MODE_DUAL;
            r_cfg.gain <= 24'd67830;
            r_cfg.bias <= '0;
            r_cfg.size <= 23'd512;
            r_cfg.rate <= 25'd8388608;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE: r_cfg.mode <= t_mode'(i_cfg_data[1:0]);
                CFG_GAIN: r_cfg.gain <= i_cfg_data[23:0];
                CFG_BIAS: r_cfg.bias <= i_cfg_data;
                CFG_SIZE: r_cfg.size <= i_cfg_data[22:0];
                CFG_RATE: r_cfg.rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    trs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_in_fire),
        .i_mode     (r_cfg.mode),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    trs_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_cfg    (r_cfg),
        .i_sample (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_last   (i_s_axis_tlast),
        .o_stat   (w_stat),
        .o_sample (w_dp_sample),
        .o_last   (w_dp_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_osample <= w_dp_sample;
            r_olast <= w_dp_last;
        end
    end

    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata = TDATA_W'($unsigned(r_osample));
    assign o_m_axis_tlast = r_olast;

endmodule

@@ sim/tube_reservoir_saturator_tb.sv @@
// tube_reservoir_saturator_tb: self-checking bench for the tube reservoir saturator.
// Depends on trs_pkg and the tube_reservoir_saturator rtl; fixed-point shaper model inside.

module tube_reservoir_saturator_tb import trs_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint QONE   = longint'(1) << 24;
    localparam longint ST_MAX = (longint'(1) << 41) - 1;
    localparam longint ST_MIN = -(longint'(1) << 41);
    localparam longint ATT    = 5536481;
    localparam longint BST    = 33808632;

    typedef struct packed {
        logic [23:0] smp;
        logic        last;
    } t_res;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [TDATA_W-1:0]    i_s_axis_tdata;
    logic                  i_s_axis_tlast;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [TDATA_W-1:0]    o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tube_reservoir_saturator u_top (.*);

    // shaper state mirrored in the bench
    longint m_mode, m_gain, m_bias, m_size, m_rate, m_push, m_pull;
    t_res   shaped_q[$];
    int     errors;
    int     send_idle, recv_stall;

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint mulq(longint a, longint b);
        longint ua, ub, r;
        ua = mag(a); ub = mag(b);
        if (ua > (longint'(1) << 46) - 1) ua = (longint'(1) << 46) - 1;
        if (ub > (longint'(1) << 38) - 1) ub = (longint'(1) << 38) - 1;
        r = (ua >>> 24) * ub + (((ua & 64'hFFFFFF) * ub + 64'h800000) >>> 24);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint softlim(longint v);
        longint unsigned uv, den, q;
        uv = mag(v);
        if (uv > (longint'(1) << 39) - 1) uv = (longint'(1) << 39) - 1;
        den = QONE + uv;
        q = ((uv << 24) + den / 2) / den;
        return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat_st(longint v);
        if (v > ST_MAX) return ST_MAX;
        if (v < ST_MIN) return ST_MIN;
        return v;
    endfunction

    function automatic longint unit_map(longint z);
        longint w;
        w = z + QONE;
        if (w < 0) w = 0;
        if (w > 2 * QONE) w = 2 * QONE;
        return w >>> 1;
    endfunction

    function automatic longint recharged(longint c);
        return sat_st(c + mulq(m_size * 65536 - c, m_rate));
    endfunction

    function automatic t_res shape_sample(logic [23:0] s, logic last);
        longint x, y, pm, nm, c, o, ao, u, a2;
        t_res   r;
        // sample aligned to 24 fraction bits, then scaled by 256 before the gain
        x = mulq(longint'($signed(s)) * 512, m_gain) + m_bias * 256;
        case (m_mode)
            MODE_SOFT: y = softlim(x);
            MODE_DUAL: begin
                m_push = recharged(m_push);
                m_pull = recharged(m_pull);
                pm = (softlim(10 * x) + QONE) >>> 1;
                nm = QONE - pm;
                c = mulq(m_push, pm) + mulq(m_pull, nm);
                o = mulq(c, softlim(mulq(x, m_rate)));
                ao = mag(o);
                m_push = sat_st(m_push - mulq(ao, pm));
                m_pull = sat_st(m_pull - mulq(ao, nm));
                y = softlim(mulq(o, ATT));
                u = unit_map(mulq(y, BST));
                y = 2 * mulq(mulq(u, u), 3 * QONE - 2 * u) - QONE;
            end
            MODE_SINGLE: begin
                m_push = recharged(m_push);
                u = unit_map(x);
                a2 = mulq(6 * u - 15 * QONE, u) + 10 * QONE;
                y = 2 * mulq(mulq(mulq(u, u), u), a2) - QONE;
                y = mulq(mulq(m_push, y), m_rate);
                m_push = sat_st(m_push - mag(y));
            end
            default: y = x;
        endcase
        if (y > 2 * QONE) y = 2 * QONE;
        if (y < -2 * QONE) y = -2 * QONE;
        y = y < 0 ? -((-y + 1) >>> 1) : (y + 1) >>> 1;
        if (y > 8388607) y = 8388607;
        if (y < -8388608) y = -8388608;
        r.smp = y[23:0];
        r.last = last;
        return r;
    endfunction

    // stateless look at a sample for the table rows with typed-in results
    function automatic logic [23:0] shape_sample_peek(logic [23:0] s);
        longint sp, sl;
        t_res   r;
        sp = m_push; sl = m_pull;
        r = shape_sample(s, 1'b0);
        m_push = sp; m_pull = sl;
        return r.smp;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_MODE: m_mode = val & 3;
            CFG_GAIN: m_gain = val & 64'hFFFFFF;
            CFG_BIAS: m_bias = longint'($signed(val[24:0]));
            CFG_SIZE: m_size = val & 64'h7FFFFF;
            CFG_RATE: m_rate = val & 64'h1FFFFFF;
            default: ;
        endcase
    endtask

    task automatic drain_and_settle();
        while (shaped_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // one sample transaction; expectation computed at accept
    task automatic send_sample(logic [23:0] s, logic last);
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        shaped_q.push_back(shape_sample(s, last));
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_m_axis_tready <= !($urandom_range(99) < recv_stall);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (shaped_q.size() == 0) begin
                    report_mismatch("unexpected result", o_m_axis_tdata, 0);
                end else begin
                    t_res e;
                    e = shaped_q.pop_front();
                    if (o_m_axis_tdata[23:0] !== e.smp)
                        report_mismatch("sample_out", o_m_axis_tdata, e.smp);
                    if (o_m_axis_tlast !== e.last)
                        report_mismatch("block_end_out", o_m_axis_tlast, e.last);
                end
            end
        end
    end

    initial begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // directed rows: mode, sample, last, expected (-1 means use the model)
    typedef struct {
        int     mode;
        logic [23:0] smp;
        logic   last;
        longint want;
    } t_row;

    t_row rows[$];

    initial begin
        logic [23:0] s;
        int          ph;
        errors = 0;
        send_idle = 0;
        recv_stall = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tlast = 1'b0;
        i_m_axis_tready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        m_mode = 1; m_gain = 67830; m_bias = 0; m_size = 512; m_rate = 8388608;
        m_push = 0; m_pull = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero input after reset: stores recharge but output stays mid-scale
        rows = '{
            '{MODE_DUAL, 24'h000000, 1'b0, -1}, '{MODE_DUAL, 24'h7FFFFF, 1'b1, -1},
            '{MODE_DUAL, 24'h800000, 1'b0, -1}, '{MODE_SOFT, 24'h000000, 1'b1, 0},
            '{MODE_SOFT, 24'h7FFFFF, 1'b0, -1}, '{MODE_SOFT, 24'h800000, 1'b0, -1},
            '{MODE_SINGLE, 24'h000000, 1'b0, -1}, '{MODE_SINGLE, 24'h7FFFFF, 1'b1, -1},
            '{MODE_SINGLE, 24'h800000, 1'b0, -1}, '{MODE_PASS, 24'h000000, 1'b0, 0},
            '{MODE_PASS, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
            '{MODE_PASS, 24'h800000, 1'b0, 24'h800000},
            '{MODE_PASS, 24'h123456, 1'b0, -1}
        };
        foreach (rows[i]) begin
            if (m_mode != rows[i].mode) begin
                drain_and_settle();
                write_reg(CFG_MODE, rows[i].mode);
            end
            if (rows[i].want >= 0 && shape_sample_peek(rows[i].smp) != rows[i].want[23:0])
                report_mismatch("directed table", shape_sample_peek(rows[i].smp),
                                rows[i].want);
            send_sample(rows[i].smp, rows[i].last);
        end

        // register extremes: out-of-range size and rate, full gain, both bias ends
        drain_and_settle();
        write_reg(CFG_GAIN, 24'hFFFFFF);
        write_reg(CFG_BIAS, -16777215);
        write_reg(CFG_SIZE, 1);
        write_reg(CFG_RATE, 25'h1FFFFFF);
        write_reg(3'd7, 5);
        for (int m = 0; m < 4; m++) begin
            drain_and_settle();
            write_reg(CFG_MODE, m);
            send_sample(24'h7FFFFF, 1'b0);
            send_sample(24'h800000, 1'b1);
        end
        drain_and_settle();
        write_reg(CFG_BIAS, 16777215);
        write_reg(CFG_SIZE, 4194304);
        write_reg(CFG_RATE, 16777216);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h000001, 1'b1);

        // random phases
        for (ph = 0; ph < 16; ph++) begin
            drain_and_settle();
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 45; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 45; end
                default: begin send_idle = 29; recv_stall = 29; end
            endcase
            write_reg(CFG_MODE, ph < 8 ? (ph % 2 ? MODE_DUAL : $urandom_range(3))
                                       : $urandom_range(3));
            write_reg(CFG_GAIN, ph == 5 ? 0 : ($urandom_range(3) == 0 ? $urandom_range(24'hFFFFFF)
                                                                       : $urandom_range(131072)));
            write_reg(CFG_BIAS, $urandom_range(1) ? $signed($urandom_range(65536)) - 32768
                                                  : $signed($urandom_range(33554431)));
            write_reg(CFG_SIZE, $urandom_range(3) == 0 ? $urandom_range(4194304, 256)
                                                       : $urandom_range(2048, 256));
            write_reg(CFG_RATE, $urandom_range(3) == 0 ? 16777216 : $urandom_range(16777216));
            for (int k = 0; k < 64; k++) begin
                s = $urandom();
                if (k == 32) while (shaped_q.size() != 0) @(posedge i_clk);
                send_sample(s, $urandom_range(1));
            end
        end

        drain_and_settle();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
